/* src/smtt_pkg.sv */
// package for the sparse matrix triplet table
// shared constants, command and status codes, controller/datapath command struct
package smtt_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int MAX_ROWS_DEF = 256;
    localparam int MAX_COLS_DEF = 256;

    localparam logic [2:0] CMD_LOAD   = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_DELETE = 3'd2;
    localparam logic [2:0] CMD_SEARCH = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic capture;     // latch the input word
        logic scan_start;  // set scan index to zero
        logic scan_rd;     // issue a read at the scan index
        logic scan_next;   // advance scan index
        logic shift_wr;    // write the just-read entry one place down
        logic append;      // write the new triplet at used_count
        logic update;      // overwrite value at scan index - 1 (match)
        logic dec_count;
        logic clear;
        logic load_step;   // advance the dense load position
        logic set_result;
        logic out_load;    // copy the result word to the output register
        logic [1:0] res_status;
        logic res_found;
        logic res_pos_hit; // position comes from the match index
        logic res_pos_app; // position comes from the append index
    } smtt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] command;
        logic       value_zero;
        logic       full;
        logic       scan_end;   // scan index reached used_count
        logic       hit;        // read data matches the latched row/col
    } smtt_stat_t;

endpackage

/* src/smtt_ram.sv */
// generic ram with separate write and read ports and registered read
// no dependencies
module smtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/smtt_datapath.sv */
// datapath: triplet memories, count, load position, scan index, result word
// depends on smtt_pkg and smtt_ram
module smtt_datapath
    import smtt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic [2:0]  command,
    input  logic [7:0]  row_index,
    input  logic [7:0]  col_index,
    input  logic signed [31:0] element_value,
    input  smtt_cmd_t   cmd,
    output smtt_stat_t  stat,
    output logic [1:0]  status,
    output logic        found,
    output logic [7:0]  entry_position,
    output logic [8:0]  entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [8:0] RMAX = (MAX_ROWS > 256) ? 9'd256 : 9'(MAX_ROWS);
    localparam logic [8:0] CMAX = (MAX_COLS > 256) ? 9'd256 : 9'(MAX_COLS);

    logic [2:0]  cmd_reg;
    logic [7:0]  row_reg, col_reg;
    logic [31:0] val_reg;
    logic [CW-1:0] used_reg;
    logic [8:0]  mrows_reg, mcols_reg;
    logic [7:0]  lrow_reg, lcol_reg;
    logic [CW-1:0] idx_reg;   // next address to read
    logic [1:0]  status_reg;
    logic        found_reg;
    logic [7:0]  pos_reg;
    logic [1:0]  out_status_reg;
    logic        out_found_reg;
    logic [7:0]  out_pos_reg;
    logic [8:0]  out_count_reg;

    logic [7:0]  rd_row, rd_col;
    logic [31:0] rd_val;
    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]  wrow, wcol;
    logic [31:0] wval;
    logic        wr_rc;
    logic [8:0]  cfg_sat;

    assign raddr = idx_reg[AW-1:0];
    // the entry read last cycle sits at idx_reg - 1
    always_comb
    begin
        we    = cmd.shift_wr | cmd.append | cmd.update;
        wr_rc = cmd.shift_wr | cmd.append;
        waddr = idx_reg[AW-1:0] - AW'(1);
        wrow  = rd_row;
        wcol  = rd_col;
        wval  = rd_val;
        if (cmd.shift_wr)
        begin
            waddr = idx_reg[AW-1:0] - AW'(2);
        end
        else if (cmd.append)
        begin
            waddr = used_reg[AW-1:0];
            wval  = val_reg;
            if (cmd_reg == CMD_LOAD)
            begin
                wrow = lrow_reg;
                wcol = lcol_reg;
            end
            else
            begin
                wrow = row_reg;
                wcol = col_reg;
            end
        end
        else if (cmd.update)
        begin
            wval = val_reg;
        end
    end

    smtt_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_rows (
        .clk(clk), .we(we & wr_rc), .waddr(waddr), .wdata(wrow),
        .raddr(raddr), .rdata(rd_row));
    smtt_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_cols (
        .clk(clk), .we(we & wr_rc), .waddr(waddr), .wdata(wcol),
        .raddr(raddr), .rdata(rd_col));
    smtt_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_vals (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wval),
        .raddr(raddr), .rdata(rd_val));

    assign stat.command    = cmd_reg;
    assign stat.value_zero = (val_reg == 32'd0);
    assign stat.full       = (used_reg == CW'(CAPACITY));
    assign stat.scan_end   = (idx_reg == used_reg);
    assign stat.hit        = (rd_row == row_reg) && (rd_col == col_reg);

    always_comb
    begin
        cfg_sat = cfg_data;
        if (cfg_sat == 9'd0)
        begin
            cfg_sat = 9'd1;
        end
        if (cfg_index == REG_ROWS && cfg_sat > RMAX)
        begin
            cfg_sat = RMAX;
        end
        if (cfg_index == REG_COLS && cfg_sat > CMAX)
        begin
            cfg_sat = CMAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg <= command;
            row_reg <= row_index;
            col_reg <= col_index;
            val_reg <= element_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            mrows_reg      <= RMAX;
            mcols_reg      <= CMAX;
            lrow_reg       <= '0;
            lcol_reg       <= '0;
            idx_reg        <= '0;
            status_reg     <= ST_DONE;
            found_reg      <= 1'b0;
            pos_reg        <= '0;
            out_status_reg <= ST_DONE;
            out_found_reg  <= 1'b0;
            out_pos_reg    <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_ROWS)
                begin
                    mrows_reg <= cfg_sat;
                end
                else
                begin
                    mcols_reg <= cfg_sat;
                end
                lrow_reg <= '0;
                lcol_reg <= '0;
            end
            if (cmd.scan_start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.scan_next)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.clear)
            begin
                used_reg <= '0;
                lrow_reg <= '0;
                lcol_reg <= '0;
            end
            else if (cmd.append)
            begin
                used_reg <= used_reg + CW'(1);
            end
            else if (cmd.dec_count)
            begin
                used_reg <= used_reg - CW'(1);
            end
            if (cmd.load_step)
            begin
                if ({1'b0, lcol_reg} + 9'd1 >= mcols_reg)
                begin
                    lcol_reg <= '0;
                    if ({1'b0, lrow_reg} + 9'd1 >= mrows_reg)
                    begin
                        lrow_reg <= '0;
                    end
                    else
                    begin
                        lrow_reg <= lrow_reg + 8'd1;
                    end
                end
                else
                begin
                    lcol_reg <= lcol_reg + 8'd1;
                end
            end
            if (cmd.set_result)
            begin
                status_reg <= cmd.res_status;
                found_reg  <= cmd.res_found;
                if (cmd.res_pos_hit)
                begin
                    pos_reg <= 8'(idx_reg - CW'(1));
                end
                else if (cmd.res_pos_app)
                begin
                    pos_reg <= 8'(used_reg);
                end
                else
                begin
                    pos_reg <= '0;
                end
            end
            // output word holds while the next command runs
            if (cmd.out_load)
            begin
                out_status_reg <= status_reg;
                out_found_reg  <= found_reg;
                out_pos_reg    <= pos_reg;
                out_count_reg  <= 9'(used_reg);
            end
        end
    end

    assign status         = out_status_reg;
    assign found          = out_found_reg;
    assign entry_position = out_pos_reg;
    assign entry_count    = out_count_reg;

endmodule

/* src/smtt_ctrl.sv */
// controller: sequences scans, shifts, appends and the output handshake
// depends on smtt_pkg
module smtt_ctrl
    import smtt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  smtt_stat_t stat,
    output smtt_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_DISPATCH, S_SCAN, S_SHIFT, S_SHIFT_LAST, S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.capture    = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                // idx is 0; read data is registered
                priority case (stat.command)
                    CMD_LOAD:
                    begin
                        cmd.load_step  = 1'b1;
                        cmd.set_result = 1'b1;
                        if (!stat.value_zero)
                        begin
                            if (stat.full)
                            begin
                                cmd.res_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.append      = 1'b1;
                                cmd.res_pos_app = 1'b1;
                            end
                        end
                        state_next = S_RESULT;
                    end
                    CMD_INSERT, CMD_DELETE, CMD_SEARCH:
                    begin
                        if (stat.scan_end)
                        begin
                            cmd.set_result = 1'b1;
                            if (stat.command == CMD_INSERT)
                            begin
                                if (stat.full)
                                begin
                                    cmd.res_status = ST_FULL;
                                end
                                else
                                begin
                                    cmd.append      = 1'b1;
                                    cmd.res_pos_app = 1'b1;
                                end
                            end
                            else
                            begin
                                cmd.res_status = ST_NOT_FOUND;
                            end
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            cmd.scan_next = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        cmd.clear      = 1'b1;
                        cmd.set_result = 1'b1;
                        state_next     = S_RESULT;
                    end
                    default:
                    begin
                        cmd.set_result = 1'b1;
                        state_next     = S_RESULT;
                    end
                endcase
            end
            S_SCAN:
            begin
                // read data is the entry at idx - 1
                if (stat.hit)
                begin
                    cmd.set_result  = 1'b1;
                    cmd.res_found   = 1'b1;
                    cmd.res_pos_hit = 1'b1;
                    if (stat.command == CMD_INSERT)
                    begin
                        cmd.update = 1'b1;
                        state_next = S_RESULT;
                    end
                    else if (stat.command == CMD_DELETE)
                    begin
                        if (stat.scan_end)
                        begin
                            cmd.dec_count = 1'b1;
                            state_next    = S_RESULT;
                        end
                        else
                        begin
                            cmd.scan_next = 1'b1;
                            state_next    = S_SHIFT;
                        end
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
                else if (stat.scan_end)
                begin
                    cmd.set_result = 1'b1;
                    if (stat.command == CMD_INSERT)
                    begin
                        if (stat.full)
                        begin
                            cmd.res_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.append      = 1'b1;
                            cmd.res_pos_app = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.res_status = ST_NOT_FOUND;
                    end
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_SHIFT:
            begin
                // move entry idx-1 to idx-2
                cmd.shift_wr = 1'b1;
                if (stat.scan_end)
                begin
                    cmd.dec_count = 1'b1;
                    state_next    = S_RESULT;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_SHIFT_LAST:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                // wait here while the previous word still sits in the output
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* src/sparse_matrix_triplet_table.sv */
// Sparse matrix triplet table: keeps up to CAPACITY (row, col, value) words in
// three RAMs with separate read and write ports and registered read. Each
// command returns one result word. Load, clear and unknown commands skip the
// scan; insert, delete and search walk the table one entry a cycle, and a
// delete keeps going to the end to move later entries down one place. The result
// word sits in an output register, so the next command is taken as soon as the
// block is idle; it then waits in its last state until that word is taken.
// Depends on smtt_pkg, smtt_ctrl, smtt_datapath, smtt_ram.
module sparse_matrix_triplet_table
    import smtt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [7:0]  row_index,
    input  logic [7:0]  col_index,
    input  logic signed [31:0] element_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        found,
    output logic [7:0]  entry_position,
    output logic [8:0]  entry_count
);

    smtt_cmd_t  cmd;
    smtt_stat_t stat;

    smtt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .stat(stat), .cmd(cmd));

    smtt_datapath #(
        .CAPACITY(CAPACITY), .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .command(command), .row_index(row_index), .col_index(col_index),
        .element_value(element_value),
        .cmd(cmd), .stat(stat),
        .status(status), .found(found),
        .entry_position(entry_position), .entry_count(entry_count));

endmodule

/* dv/tb_sparse_matrix_triplet_table.sv */
// testbench for sparse_matrix_triplet_table: random and directed commands
// checked against an in-bench triplet table predictor; depends on smtt_pkg
module tb_sparse_matrix_triplet_table;
    import smtt_pkg::*;

    int unsigned fail_count;

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    class triplet_scoreboard;
        logic [7:0]  tab_row[256];
        logic [7:0]  tab_col[256];
        logic [31:0] tab_val[256];
        int unsigned used;
        int unsigned pos_row, pos_col;
        int unsigned dim_rows, dim_cols;
        logic [1:0] exp_status[$];
        logic       exp_found[$];
        logic [7:0] exp_pos[$];
        logic [8:0] exp_count[$];
        int unsigned errors;
        int unsigned checked;

        function new();
            used = 0; pos_row = 0; pos_col = 0;
            dim_rows = 256; dim_cols = 256;
            errors = 0; checked = 0;
        endfunction

        function void set_dim(logic idx, logic [8:0] val);
            int unsigned v;
            v = (val == 0) ? 1 : ((val > 256) ? 256 : val);
            if (idx == REG_ROWS) dim_rows = v;
            else dim_cols = v;
            pos_row = 0; pos_col = 0;
        endfunction

        function int lookup(logic [7:0] r, logic [7:0] c);
            for (int i = 0; i < used; i++)
                if (tab_row[i] == r && tab_col[i] == c) return i;
            return -1;
        endfunction

        function void note_word(logic [2:0] cmd, logic [7:0] r, logic [7:0] c,
                                logic [31:0] v);
            logic [1:0] st;
            logic       fd;
            int         p;
            int         hit;
            st = ST_DONE; fd = 0; p = 0;
            case (cmd)
                CMD_LOAD:
                begin
                    if (v != 0) begin
                        if (used >= 256) st = ST_FULL;
                        else begin
                            tab_row[used] = pos_row[7:0]; tab_col[used] = pos_col[7:0];
                            tab_val[used] = v; p = used; used++;
                        end
                    end
                    pos_col++;
                    if (pos_col >= dim_cols) begin
                        pos_col = 0; pos_row++;
                        if (pos_row >= dim_rows) pos_row = 0;
                    end
                end
                CMD_INSERT:
                begin
                    hit = lookup(r, c);
                    if (hit >= 0) begin
                        tab_val[hit] = v; fd = 1; p = hit;
                    end else if (used >= 256) st = ST_FULL;
                    else begin
                        tab_row[used] = r; tab_col[used] = c; tab_val[used] = v;
                        p = used; used++;
                    end
                end
                CMD_DELETE:
                begin
                    hit = lookup(r, c);
                    if (hit >= 0) begin
                        for (int k = hit; k + 1 < used; k++) begin
                            tab_row[k] = tab_row[k+1]; tab_col[k] = tab_col[k+1];
                            tab_val[k] = tab_val[k+1];
                        end
                        used--; fd = 1; p = hit;
                    end else st = ST_NOT_FOUND;
                end
                CMD_SEARCH:
                begin
                    hit = lookup(r, c);
                    if (hit >= 0) begin
                        fd = 1; p = hit;
                    end else st = ST_NOT_FOUND;
                end
                CMD_CLEAR:
                begin
                    used = 0; pos_row = 0; pos_col = 0;
                end
                default: ;
            endcase
            exp_status.push_back(st);
            exp_found.push_back(fd);
            exp_pos.push_back(p[7:0]);
            exp_count.push_back(used[8:0]);
        endfunction

        task check_word(logic [1:0] st, logic fd, logic [7:0] p, logic [8:0] n);
            logic [1:0] es;
            logic       ef;
            logic [7:0] ep;
            logic [8:0] en;
            checked++;
            if (exp_status.size() == 0) begin
                report_mismatch("result word with nothing expected");
                return;
            end
            es = exp_status.pop_front(); ef = exp_found.pop_front();
            ep = exp_pos.pop_front(); en = exp_count.pop_front();
            if (st !== es) report_mismatch($sformatf("status %0d, want %0d", st, es));
            if (fd !== ef) report_mismatch($sformatf("found %0d, want %0d", fd, ef));
            if (p !== ep) report_mismatch($sformatf("entry_position %0d, want %0d", p, ep));
            if (n !== en) report_mismatch($sformatf("entry_count %0d, want %0d", n, en));
        endtask

        function int pending();
            return exp_status.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [8:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  command;
    logic [7:0]  row_index;
    logic [7:0]  col_index;
    logic signed [31:0] element_value;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic        found;
    logic [7:0]  entry_position;
    logic [8:0]  entry_count;

    triplet_scoreboard sb;
    bit          hold_off;
    int unsigned n_sent;

    sparse_matrix_triplet_table u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .row_index(row_index), .col_index(col_index),
        .element_value(element_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .found(found), .entry_position(entry_position),
        .entry_count(entry_count)
    );

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // valid stays high after an accept until the next gap or idle point
    task automatic send_word(logic [2:0] cmd, logic [7:0] r, logic [7:0] c,
                             logic [31:0] v);
        int unsigned gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1; command <= cmd; row_index <= r; col_index <= c;
        element_value <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_word(cmd, r, c, v);
        n_sent++;
    endtask

    task automatic write_dim(logic idx, logic [8:0] val);
        // block must be idle: wait until all results are back, then a settling wait
        in_valid <= 0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        sb.set_dim(idx, val);
    endtask

    // hit-biased random row/col so searches and deletes often match
    task automatic random_cmd();
        logic [2:0] cmd;
        logic [7:0] r, c;
        logic [31:0] v;
        int unsigned sel;
        int unsigned k;
        sel = $urandom_range(0, 99);
        if (sel < 30) cmd = CMD_LOAD;
        else if (sel < 55) cmd = CMD_INSERT;
        else if (sel < 72) cmd = CMD_DELETE;
        else if (sel < 92) cmd = CMD_SEARCH;
        else if (sel < 95) cmd = CMD_CLEAR;
        else cmd = 3'($urandom_range(5, 7));
        r = 8'($urandom); c = 8'($urandom);
        if (sb.used > 0 && $urandom_range(0, 1)) begin
            k = $urandom_range(0, sb.used - 1);
            r = sb.tab_row[k]; c = sb.tab_col[k];
        end
        case ($urandom_range(0, 5))
            0: v = 0;
            1: v = 32'h8000_0000;
            2: v = 32'h7fff_ffff;
            default: v = $urandom;
        endcase
        send_word(cmd, r, c, v);
    endtask

    // receiver: random wait before each word, longer while held off
    initial begin
        int unsigned gap;
        out_ready = 0;
        forever begin
            gap = $urandom_range(0, 10);
            if (gap > 0 || hold_off) begin
                out_ready <= 0;
                repeat (gap) @(posedge clk);
                while (hold_off) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_word(status, found, entry_position, entry_count);

    initial begin
        #8000000;
        $display("[sparse_matrix_triplet_table] ERROR");
        $finish;
    end

    initial begin
        int unsigned wait_cnt;
        sb = new();
        fail_count = 0; hold_off = 0; n_sent = 0;
        rst_n = 0; cfg_we = 0; cfg_index = REG_ROWS; cfg_data = 0;
        in_valid = 0; command = CMD_LOAD; row_index = 0; col_index = 0;
        element_value = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: small dense matrix, extremes and every command
        write_dim(REG_ROWS, 9'd2);
        write_dim(REG_COLS, 9'd3);
        send_word(CMD_LOAD, 8'd0, 8'd0, 32'd5);
        send_word(CMD_LOAD, 8'd0, 8'd0, 32'd0);
        send_word(CMD_LOAD, 8'd0, 8'd0, 32'h8000_0000);
        send_word(CMD_LOAD, 8'd0, 8'd0, 32'h7fff_ffff);
        send_word(CMD_LOAD, 8'd0, 8'd0, 32'hffff_ffff);
        send_word(CMD_LOAD, 8'd0, 8'd0, 32'd1);
        send_word(CMD_LOAD, 8'd0, 8'd0, 32'd9);  // position wraps to (0,0)
        send_word(CMD_SEARCH, 8'd0, 8'd0, 32'd0);
        send_word(CMD_SEARCH, 8'd255, 8'd255, 32'd0);
        send_word(CMD_INSERT, 8'd255, 8'd255, 32'd0);
        send_word(CMD_INSERT, 8'd0, 8'd2, 32'd77);
        send_word(CMD_DELETE, 8'd0, 8'd0, 32'd0);
        send_word(CMD_DELETE, 8'd0, 8'd0, 32'd0);
        send_word(CMD_SEARCH, 8'd1, 8'd2, 32'd0);
        send_word(CMD_DELETE, 8'd255, 8'd255, 32'd0);
        send_word(3'd5, 8'd0, 8'd0, 32'd0);
        send_word(3'd7, 8'hff, 8'hff, 32'hffff_ffff);
        send_word(CMD_CLEAR, 8'd0, 8'd0, 32'd0);
        write_dim(REG_ROWS, 9'd0);
        write_dim(REG_COLS, 9'h1ff);

        // fill the table to capacity, then refused appends
        for (int i = 0; i < 258; i++) send_word(CMD_LOAD, 8'd0, 8'd0, 32'($urandom | 1));
        send_word(CMD_INSERT, 8'd200, 8'd9, 32'd3);
        send_word(CMD_INSERT, 8'd0, 8'd5, 32'd3);
        send_word(CMD_DELETE, 8'd0, 8'd100, 32'd0);
        send_word(CMD_SEARCH, 8'd0, 8'd255, 32'd0);
        send_word(CMD_CLEAR, 8'd0, 8'd0, 32'd0);

        // receiver hold-off while the sender keeps going
        fork
            begin
                hold_off = 1;
                wait_cnt = 0;
                while (wait_cnt < 400) begin
                    @(posedge clk);
                    wait_cnt++;
                end
                hold_off = 0;
            end
            for (int i = 0; i < 20; i++) random_cmd();
        join

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin write_dim(REG_ROWS, 9'd256); write_dim(REG_COLS, 9'd1); end
                1: begin write_dim(REG_ROWS, 9'd4); write_dim(REG_COLS, 9'd5); end
                2: begin write_dim(REG_ROWS, 9'd1); write_dim(REG_COLS, 9'd256); end
                default: begin
                    write_dim(REG_ROWS, 9'($urandom_range(1, 300)));
                    write_dim(REG_COLS, 9'($urandom_range(0, 511)));
                end
            endcase
            for (int i = 0; i < 210; i++) random_cmd();
        end

        in_valid <= 0;
        wait_cnt = 0;
        while (sb.pending() != 0 && wait_cnt < 200000) begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (300) @(posedge clk);
        if (sb.pending() != 0) report_mismatch("results still expected at end of run");
        $display("covered %0d commands and %0d result words over six dimension settings",
                 n_sent, sb.checked);
        $display("including a filled table and a long output stall");
        if (fail_count == 0 && sb.pending() == 0)
            $display("[sparse_matrix_triplet_table] OK");
        else
            $display("[sparse_matrix_triplet_table] ERROR");
        $finish;
    end
endmodule

/* sparse_matrix_triplet_table.f */
src/smtt_pkg.sv
src/smtt_ram.sv
src/smtt_datapath.sv
src/smtt_ctrl.sv
src/sparse_matrix_triplet_table.sv
dv/tb_sparse_matrix_triplet_table.sv
